// ===== src/pem_pkg.sv =====
// shared types, sizes and constants for the prewitt edge magnitude block
`timescale 1ns / 1ps

package pem_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    // coordinate and size widths
    localparam int COORD_W = $clog2(MAX_WIDTH);
    localparam int SIZE_W  = 13;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = PIX_W + 2;
    localparam int GRAD_W  = SUM_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic signed [GRAD_W-1:0] t_grad;

    // bound a configured size to [MIN_SIZE, hi]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_W'(MIN_SIZE)) begin
            res = SIZE_W'(MIN_SIZE);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== src/pem_magnitude.sv =====
// absolute value, clamping and saturating sum of the two gradients
`timescale 1ns / 1ps

module pem_magnitude (
    input  pem_pkg::t_grad                i_gv,
    input  pem_pkg::t_grad                i_gh,
    output logic [pem_pkg::PIX_W-1:0]     o_magnitude
);

    logic [pem_pkg::GRAD_W-1:0] abs_v;
    logic [pem_pkg::GRAD_W-1:0] abs_h;
    logic [pem_pkg::PIX_W-1:0]  clip_v;
    logic [pem_pkg::PIX_W-1:0]  clip_h;
    logic [pem_pkg::PIX_W:0]    sum;

    always_comb begin
        abs_v = i_gv[pem_pkg::GRAD_W-1] ? pem_pkg::GRAD_W'(-i_gv) : pem_pkg::GRAD_W'(i_gv);
        abs_h = i_gh[pem_pkg::GRAD_W-1] ? pem_pkg::GRAD_W'(-i_gh) : pem_pkg::GRAD_W'(i_gh);
        clip_v = (abs_v > pem_pkg::GRAD_W'(pem_pkg::PIX_MAX)) ? pem_pkg::PIX_MAX
                                                               : abs_v[pem_pkg::PIX_W-1:0];
        clip_h = (abs_h > pem_pkg::GRAD_W'(pem_pkg::PIX_MAX)) ? pem_pkg::PIX_MAX
                                                               : abs_h[pem_pkg::PIX_W-1:0];
        sum = {1'b0, clip_v} + {1'b0, clip_h};
        o_magnitude = sum[pem_pkg::PIX_W] ? pem_pkg::PIX_MAX : sum[pem_pkg::PIX_W-1:0];
    end

endmodule

// ===== src/prewitt_edge_magnitude.sv =====
// top level: line memories, 3x3 window, pipeline control and register port
`timescale 1ns / 1ps

// Streaming 3x3 Prewitt edge magnitude.
// Input channel: one 8-bit grey pixel per transaction in raster order (i_valid /
// o_stall). Output channel: one transaction per interior pixel carrying its row,
// column, magnitude and a flag on the last interior pixel of the image
// (o_valid / i_stall). Border pixels give no output transaction.
// Image width and height are set through the APB port (width at 0x0, height at
// 0x4); any write restarts the frame at pixel (0,0). Write only while idle.
// Throughput: one pixel per clock while o_stall is low. Each transaction reads both
// line memories at its column and writes them back as it leaves the first stage; the
// next pixel always uses another column, so read and write never meet on one entry.
// Once its last pixel is taken, a result passes the stage 1, gradient and output registers.
// Pipeline: memory read / window stage, gradient register, output register. Each
// stage advances on its own, so a stalled result still lets at least two more pixels in.
// Reset: counters, window and valid flags clear, sizes return to 640 x 480; the
// line memories are not cleared (rows 0 and 1 never produce output).
// When the receiver stalls the output holds and o_stall rises once all stages fill.
module prewitt_edge_magnitude (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pem_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pem_pkg::COORD_W-1:0]       o_out_row,
    output logic [pem_pkg::COORD_W-1:0]       o_out_col,
    output logic [pem_pkg::PIX_W-1:0]         o_magnitude,
    output logic                              o_last_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pem_pkg::PADDR_W-1:0]       paddr,
    input  logic [pem_pkg::PDATA_W-1:0]       pwdata,
    output logic [pem_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int CW = pem_pkg::COORD_W;
    localparam int SW = pem_pkg::SIZE_W;
    localparam int PW = pem_pkg::PIX_W;

    // configuration
    logic [SW-1:0] r_width;
    logic [SW-1:0] r_height;
    logic          cfg_wr;
    pem_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = pem_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pem_pkg::WIDTH_RESET;
            r_height <= pem_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pem_pkg::REG_WIDTH:  r_width  <= pwdata[SW-1:0];
                pem_pkg::REG_HEIGHT: r_height <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pem_pkg::REG_WIDTH:  prdata = pem_pkg::PDATA_W'(r_width);
            pem_pkg::REG_HEIGHT: prdata = pem_pkg::PDATA_W'(r_height);
            default:             prdata = '0;
        endcase
    end

    // pipeline handshake
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic adv_out;
    logic adv_s2;
    logic s1_go;
    logic acc;

    assign adv_out = !r_out_valid || !i_stall;
    assign adv_s2  = !r_s2_valid || adv_out;
    assign o_stall = r_s1_valid && !adv_s2;
    assign acc     = i_valid && !o_stall;
    assign s1_go   = r_s1_valid && adv_s2;
    assign o_valid = r_out_valid;

    // position counters
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic          col_end;
    logic          row_end;

    always_comb begin
        w_eff   = pem_pkg::clamp_size(r_width,  SW'(pem_pkg::MAX_WIDTH));
        h_eff   = pem_pkg::clamp_size(r_height, SW'(pem_pkg::MAX_HEIGHT));
        col_end = ({1'b0, r_col} + SW'(1)) >= w_eff;
        row_end = ({1'b0, r_row} + SW'(1)) >= h_eff;
        n_col   = r_col;
        n_row   = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line memory read data, pixel and position
    logic [PW-1:0] r_s1_px;
    logic [CW-1:0] r_s1_addr;
    logic          r_s1_emit;
    logic          r_s1_last;
    logic [CW-1:0] r_s1_row;
    logic [CW-1:0] r_s1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= r_col;
            r_s1_emit <= (r_row >= CW'(2)) && (r_col >= CW'(2));
            r_s1_last <= row_end && col_end;
            r_s1_row  <= r_row - CW'(1);
            r_s1_col  <= r_col - CW'(1);
        end
    end

    // line memories: a holds the row above, b the row two above
    logic [PW-1:0] r_line_a [0:pem_pkg::MAX_WIDTH-1];
    logic [PW-1:0] r_line_b [0:pem_pkg::MAX_WIDTH-1];
    logic [PW-1:0] r_rd_a;
    logic [PW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_a <= r_line_a[r_col];
        end
        if (s1_go) begin
            r_line_a[r_s1_addr] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_b <= r_line_b[r_col];
        end
        if (s1_go) begin
            r_line_b[r_s1_addr] <= r_rd_a;
        end
    end

    // window: [0..2] column c-1 top/mid/bottom, [3..5] column c-2
    logic [PW-1:0] r_win [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_go) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= r_rd_b;
            r_win[1] <= r_rd_a;
            r_win[2] <= r_s1_px;
        end
    end

    logic [pem_pkg::SUM_W-1:0] sum_below;
    logic [pem_pkg::SUM_W-1:0] sum_above;
    logic [pem_pkg::SUM_W-1:0] sum_right;
    logic [pem_pkg::SUM_W-1:0] sum_left;
    pem_pkg::t_grad            n_gv;
    pem_pkg::t_grad            n_gh;

    always_comb begin
        sum_below = pem_pkg::SUM_W'(r_win[5]) + pem_pkg::SUM_W'(r_win[2])
                  + pem_pkg::SUM_W'(r_s1_px);
        sum_above = pem_pkg::SUM_W'(r_win[3]) + pem_pkg::SUM_W'(r_win[0])
                  + pem_pkg::SUM_W'(r_rd_b);
        sum_right = pem_pkg::SUM_W'(r_rd_b) + pem_pkg::SUM_W'(r_rd_a)
                  + pem_pkg::SUM_W'(r_s1_px);
        sum_left  = pem_pkg::SUM_W'(r_win[3]) + pem_pkg::SUM_W'(r_win[4])
                  + pem_pkg::SUM_W'(r_win[5]);
        n_gv = $signed({1'b0, sum_below}) - $signed({1'b0, sum_above});
        n_gh = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    end

    // stage 2: gradients
    pem_pkg::t_grad r_s2_gv;
    pem_pkg::t_grad r_s2_gh;
    logic           r_s2_last;
    logic [CW-1:0]  r_s2_row;
    logic [CW-1:0]  r_s2_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv_s2) begin
            r_s2_valid <= s1_go && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s2) begin
            r_s2_gv   <= n_gv;
            r_s2_gh   <= n_gh;
            r_s2_last <= r_s1_last;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
        end
    end

    logic [PW-1:0] mag;

    pem_magnitude u_mag (
        .i_gv        (r_s2_gv),
        .i_gh        (r_s2_gh),
        .o_magnitude (mag)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            o_out_row     <= r_s2_row;
            o_out_col     <= r_s2_col;
            o_magnitude   <= mag;
            o_last_result <= r_s2_last;
        end
    end

endmodule

// ===== tb/tb_prewitt_edge_magnitude.sv =====
// testbench for prewitt_edge_magnitude: streams images, predicts every result and checks it
`timescale 1ns / 1ps

module tb_prewitt_edge_magnitude;

    localparam int COORD_W    = pem_pkg::COORD_W;
    localparam int SIZE_W     = pem_pkg::SIZE_W;
    localparam int PIX_W      = pem_pkg::PIX_W;
    localparam int PADDR_W    = pem_pkg::PADDR_W;
    localparam int PDATA_W    = pem_pkg::PDATA_W;
    localparam int MIN_SIZE   = pem_pkg::MIN_SIZE;
    localparam int MAX_WIDTH  = pem_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = pem_pkg::MAX_HEIGHT;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 830;
    localparam int BORDER_RUN    = 24;
    localparam int WIDE_RUN      = 64;
    localparam int TALL_ROWS     = 20;
    localparam int BACKLOG_HOLD  = 150;
    localparam int CYCLE_LIMIT   = 500_000;

    typedef enum int {
        CONTENT_NOISE,
        CONTENT_FLAT,
        CONTENT_BINARY,
        CONTENT_RAMP
    } t_content;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   magnitude;
        logic               last_flag;
    } t_edge_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [PIX_W-1:0]    i_pixel;
    logic                o_valid;
    logic                i_stall;
    logic [COORD_W-1:0]  o_out_row;
    logic [COORD_W-1:0]  o_out_col;
    logic [PIX_W-1:0]    o_magnitude;
    logic                o_last_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    prewitt_edge_magnitude i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_magnitude   (o_magnitude),
        .o_last_result (o_last_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [SIZE_W-1:0] cfg_width  = pem_pkg::WIDTH_RESET;
    logic [SIZE_W-1:0] cfg_height = pem_pkg::HEIGHT_RESET;
    logic [PIX_W-1:0]  line_newer [MAX_WIDTH];
    logic [PIX_W-1:0]  line_older [MAX_WIDTH];
    logic [PIX_W-1:0]  win_px [6];
    int                col_pos = 0;
    int                row_pos = 0;

    t_edge_result predicted_results [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  sink_wait      = 0;
    int  hold_left      = 0;
    bit  src_idle_on    = 1'b0;
    bit  sink_idle_on   = 1'b0;

    always begin
        #1 i_clk = 1'b0;
        #1 i_clk = 1'b1;
    end

    function automatic int draw_gap(input bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic int bounded_size(input logic [SIZE_W-1:0] v, input int hi);
        if (int'(v) < MIN_SIZE) begin
            return MIN_SIZE;
        end
        return (int'(v) > hi) ? hi : int'(v);
    endfunction

    function automatic int clip_abs(input int v);
        int a;
        a = (v < 0) ? -v : v;
        return (a > int'(pem_pkg::PIX_MAX)) ? int'(pem_pkg::PIX_MAX) : a;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input t_content mode, input int idx,
                                                    input logic [PIX_W-1:0] base);
        case (mode)
            CONTENT_FLAT:   return base;
            CONTENT_BINARY: return ($urandom_range(0, 1) != 0) ? pem_pkg::PIX_MAX : '0;
            CONTENT_RAMP:   return PIX_W'(int'(base) + idx * 3);
            default:        return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one source pixel through the window; queues the result of the interior pixel it completes
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int w, h, c, r;
        int below_sum, above_sum, right_sum, left_sum, mag;
        logic [PIX_W-1:0] px_up2, px_up1;
        t_edge_result res;
        w = bounded_size(cfg_width, MAX_WIDTH);
        h = bounded_size(cfg_height, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        px_up2 = line_older[c];
        px_up1 = line_newer[c];
        if (r >= 2 && c >= 2) begin
            // win_px[0..2] hold column c-1 (up2, up1, px), win_px[3..5] column c-2
            below_sum = int'(win_px[5]) + int'(win_px[2]) + int'(px);
            above_sum = int'(win_px[3]) + int'(win_px[0]) + int'(px_up2);
            right_sum = int'(px_up2) + int'(px_up1) + int'(px);
            left_sum  = int'(win_px[3]) + int'(win_px[4]) + int'(win_px[5]);
            mag = clip_abs(below_sum - above_sum) + clip_abs(right_sum - left_sum);
            if (mag > int'(pem_pkg::PIX_MAX)) begin
                mag = int'(pem_pkg::PIX_MAX);
            end
            res.row       = COORD_W'(r - 1);
            res.col       = COORD_W'(c - 1);
            res.magnitude = PIX_W'(mag);
            res.last_flag = (r == h - 1) && (c == w - 1);
            predicted_results.push_back(res);
        end
        win_px[3] = win_px[0];
        win_px[4] = win_px[1];
        win_px[5] = win_px[2];
        win_px[0] = px_up2;
        win_px[1] = px_up1;
        win_px[2] = px;
        line_older[c] = px_up1;
        line_newer[c] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // output side: each accepted transaction against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_edge_result want;
        if (o_valid === 1'b1 && i_stall === 1'b0) begin
            sink_wait = draw_gap(sink_idle_on);
            if (predicted_results.size() == 0) begin
                $display("%0t: result expected none actual row %0d col %0d magnitude %0d last %0b",
                         $time, o_out_row, o_out_col, o_magnitude, o_last_result);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                check_field("row", 32'(want.row), 32'(o_out_row));
                check_field("col", 32'(want.col), 32'(o_out_col));
                check_field("magnitude", 32'(want.magnitude), 32'(o_magnitude));
                check_field("last_result", 32'(want.last_flag), 32'(o_last_result));
            end
        end
    end

    // receiver stall: long hold-off first, then per-transaction waits
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (sink_wait > 0) begin
            i_stall <= 1'b1;
            sink_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("prewitt_edge_magnitude: mismatch");
            $finish;
        end
    end

    // returns at the rising edge that took the pixel; valid stays up for a back-to-back pixel
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = draw_gap(src_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_pixel <= PIX_W'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_pixel(px);
    endtask

    task automatic send_run(input int count, input t_content mode);
        logic [PIX_W-1:0] base;
        base = PIX_W'($urandom_range(0, 255));
        for (int i = 0; i < count; i++) begin
            send_pixel(pick_pixel(mode, i, base));
        end
    endtask

    // drop valid, collect every predicted result, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input pem_pkg::t_reg_idx idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input pem_pkg::t_reg_idx idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        if (idx == pem_pkg::REG_WIDTH) begin
            cfg_width = value[SIZE_W-1:0];
        end else begin
            cfg_height = value[SIZE_W-1:0];
        end
        // any register write restarts the frame
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic check_register(input pem_pkg::t_reg_idx idx);
        logic [PDATA_W-1:0] got;
        apb_access(1'b0, idx, '0, got);
        check_field((idx == pem_pkg::REG_WIDTH) ? "image_width" : "image_height",
                    PDATA_W'((idx == pem_pkg::REG_WIDTH) ? cfg_width : cfg_height), got);
    endtask

    // reset sizes: the first pixels of a 640-wide image are border pixels and give nothing
    task automatic test_reset_defaults();
        check_register(pem_pkg::REG_WIDTH);
        check_register(pem_pkg::REG_HEIGHT);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_run(BORDER_RUN, CONTENT_NOISE);
        settle();
    endtask

    // 3x3 images from sizes below the minimum; saturating and negative gradients
    task automatic test_directed_patterns();
        logic [71:0] patches [3];
        patches[0] = 72'hFFFFFF_000000_000000;  // bright row above only
        patches[1] = 72'h0000FF_0000FF_FFFFFF;  // both gradients past the clamp
        patches[2] = 72'h090807_060504_030201;  // small negative gradients
        write_reg(pem_pkg::REG_WIDTH, '0);
        write_reg(pem_pkg::REG_HEIGHT, 32'd2);
        check_register(pem_pkg::REG_WIDTH);
        check_register(pem_pkg::REG_HEIGHT);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        // back-to-back images also cover the wrap at the end of each image
        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < 9; i++) begin
                send_pixel(patches[p][71 - 8 * i -: 8]);
            end
        end
        settle();
    endtask

    // receiver holds off while pixels keep coming, so the block fills and stalls its input
    task automatic test_output_backpressure();
        write_reg(pem_pkg::REG_WIDTH, 32'd8);
        write_reg(pem_pkg::REG_HEIGHT, 32'd6);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        hold_left = BACKLOG_HOLD;
        send_run(48, CONTENT_NOISE);
        settle();
    endtask

    task automatic test_random_images();
        int sent, w_raw, h_raw, frames, full, count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       w_raw = $urandom_range(0, 2);
                1:       w_raw = MIN_SIZE;
                default: w_raw = $urandom_range(3, 40);
            endcase
            h_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            if ($urandom_range(0, 1) != 0) begin
                write_reg(pem_pkg::REG_HEIGHT, PDATA_W'(h_raw));
                write_reg(pem_pkg::REG_WIDTH, PDATA_W'(w_raw));
            end else if ($urandom_range(0, 2) != 0) begin
                write_reg(pem_pkg::REG_WIDTH, PDATA_W'(w_raw));
            end else begin
                write_reg(pem_pkg::REG_HEIGHT, PDATA_W'(h_raw));
            end
            if ($urandom_range(0, 3) == 0) begin
                check_register(pem_pkg::REG_WIDTH);
                check_register(pem_pkg::REG_HEIGHT);
            end
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            full   = bounded_size(cfg_width, MAX_WIDTH) * bounded_size(cfg_height, MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                count = full;
                // a cut-short last image checks the restart on the next write
                if (f == frames - 1 && $urandom_range(0, 3) == 0) begin
                    count = $urandom_range(1, full - 1);
                end
                // keep the total within the item budget
                if (count > RANDOM_ITEMS - sent) begin
                    count = RANDOM_ITEMS - sent;
                end
                send_run(count, t_content'($urandom_range(0, 3)));
                sent += count;
            end
            settle();
        end
    endtask

    // widest and tallest sizes, reached through sizes above the maximum
    task automatic test_largest_sizes();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_reg(pem_pkg::REG_WIDTH, PDATA_W'((1 << SIZE_W) - 1));
        write_reg(pem_pkg::REG_HEIGHT, 32'd3);
        check_register(pem_pkg::REG_WIDTH);
        send_run(WIDE_RUN, CONTENT_NOISE);
        settle();
        write_reg(pem_pkg::REG_WIDTH, 32'd3);
        write_reg(pem_pkg::REG_HEIGHT, PDATA_W'(MAX_HEIGHT + 1));
        check_register(pem_pkg::REG_HEIGHT);
        send_run(3 * TALL_ROWS, CONTENT_BINARY);
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_stall = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        foreach (line_newer[i]) begin
            line_newer[i] = '0;
            line_older[i] = '0;
        end
        foreach (win_px[i]) begin
            win_px[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_patterns();
        test_output_backpressure();
        test_random_images();
        test_largest_sizes();
        settle();

        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("prewitt_edge_magnitude: match");
        end else begin
            $display("prewitt_edge_magnitude: mismatch");
        end
        $finish;
    end

endmodule
